### rtl/core/ums_pkg.sv
// Shared constants, types and functions for the 3x3 unsharp mask block.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package ums_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W     = 8;
    localparam int DIM_W     = 11;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
    localparam logic [DIM_W-1:0] DIM_MIN      = DIM_W'(3);

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef logic [8:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } t_meta;

    typedef struct packed {
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] px;
        t_meta            meta;
    } t_s1;

    // Saturate a dimension register to 3..hi.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
        if (v < DIM_MIN) begin
            return DIM_MIN;
        end else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // 3p - 2*floor(binomial/16), clamped to a byte.
    function automatic logic [PIX_W-1:0] sharpen(input t_win win);
        logic [11:0]        sum;
        logic [PIX_W-1:0]   blur;
        logic signed [11:0] v;
        sum = 12'(win[0]) + (12'(win[1]) << 1) + 12'(win[2])
            + (12'(win[3]) << 1) + (12'(win[4]) << 2) + (12'(win[5]) << 1)
            + 12'(win[6]) + (12'(win[7]) << 1) + 12'(win[8]);
        blur = sum[11:4];
        v = $signed(12'(win[4]) + (12'(win[4]) << 1)) - $signed({3'b000, blur, 1'b0});
        if (v < 12'sd0) begin
            return '0;
        end else if (v > 12'sd255) begin
            return '1;
        end
        return v[PIX_W-1:0];
    endfunction

endpackage

### rtl/core/ums_if.sv
// Valid/ready channel interfaces: pixel input, pixel output and config write.
// Depends on ums_pkg for field widths.
interface ums_pix_in_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [ums_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output cmd, output pixel_in, input ready);
    modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

interface ums_pix_out_if;
    logic                      valid;
    logic                      ready;
    logic [ums_pkg::PIX_W-1:0] pixel_out;
    logic                      frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

interface ums_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ums_pkg::CFG_IDX_W-1:0] addr;
    logic [ums_pkg::DIM_W-1:0]     data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

### rtl/core/ums_cfg.sv
// Configuration registers for frame width and height, with saturated copies.
// Depends on ums_pkg and ums_cfg_if.
module ums_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    ums_cfg_if.sink                   i_cfg,
    output logic [ums_pkg::DIM_W-1:0] o_width,
    output logic [ums_pkg::DIM_W-1:0] o_height
);

    logic [ums_pkg::DIM_W-1:0] r_width, n_width;
    logic [ums_pkg::DIM_W-1:0] r_height, n_height;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg.valid) begin
            case (i_cfg.addr)
                ums_pkg::REG_IMAGE_WIDTH:  n_width  = i_cfg.data;
                ums_pkg::REG_IMAGE_HEIGHT: n_height = i_cfg.data;
                default: ;  // unknown register: drop
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ums_pkg::WIDTH_RESET;
            r_height <= ums_pkg::HEIGHT_RESET;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    assign o_width  = ums_pkg::eff_dim(r_width, ums_pkg::DIM_W'(ums_pkg::MAX_WIDTH));
    assign o_height = ums_pkg::eff_dim(r_height, ums_pkg::DIM_W'(ums_pkg::MAX_HEIGHT));

endmodule

### rtl/core/ums_ctrl.sv
// Input and output position counters; decides per transaction whether it
// enters the pipeline, emits a result, is interior, or ends the frame.
// Depends on ums_pkg.
module ums_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [ums_pkg::DIM_W-1:0] i_width,
    input  logic [ums_pkg::DIM_W-1:0] i_height,
    input  logic                      i_fire,
    input  logic                      i_cmd,
    output logic                      o_enter,
    output logic                      o_in_frame,
    output logic [ums_pkg::COL_W-1:0] o_col,
    output ums_pkg::t_meta            o_meta
);

    logic [ums_pkg::COL_W-1:0] r_in_col, n_in_col;
    logic [ums_pkg::DIM_W-1:0] r_in_row, n_in_row;
    logic [ums_pkg::COL_W-1:0] r_out_col, n_out_col;
    logic [ums_pkg::ROW_W-1:0] r_out_row, n_out_row;

    logic [ums_pkg::DIM_W-1:0] w_m1, w_m2, h_m1, h_m2;
    logic                      in_col_last, out_col_last;

    always_comb begin
        w_m1 = i_width - ums_pkg::DIM_W'(1);
        w_m2 = i_width - ums_pkg::DIM_W'(2);
        h_m1 = i_height - ums_pkg::DIM_W'(1);
        h_m2 = i_height - ums_pkg::DIM_W'(2);

        o_in_frame = r_in_row < i_height;
        // Drain tick while the frame is still arriving: ignore it.
        o_enter = i_fire && !(i_cmd == ums_pkg::CMD_DRAIN && o_in_frame);
        o_col   = r_in_col;

        o_meta.emit = (r_in_row >= ums_pkg::DIM_W'(2))
                   || (r_in_row == ums_pkg::DIM_W'(1) && r_in_col != '0);
        o_meta.interior = r_out_row != '0 && ums_pkg::DIM_W'(r_out_row) <= h_m2
                       && r_out_col != '0 && ums_pkg::DIM_W'(r_out_col) <= w_m2;
        out_col_last = ums_pkg::DIM_W'(r_out_col) == w_m1;
        o_meta.last  = out_col_last && ums_pkg::DIM_W'(r_out_row) == h_m1;

        in_col_last = ums_pkg::DIM_W'(r_in_col) == w_m1;

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (o_enter) begin
            if (in_col_last) begin
                n_in_col = '0;
                if (r_in_row != '1) begin
                    n_in_row = r_in_row + ums_pkg::DIM_W'(1);
                end
            end else begin
                n_in_col = r_in_col + ums_pkg::COL_W'(1);
            end
            if (o_meta.emit) begin
                if (o_meta.last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (out_col_last) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + ums_pkg::ROW_W'(1);
                end else begin
                    n_out_col = r_out_col + ums_pkg::COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

endmodule

### rtl/core/ums_line_buf.sv
// Two line stores and the first pipeline stage that holds their read data.
// Depends on ums_pkg.
module ums_line_buf (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_enter,
    input  logic [ums_pkg::COL_W-1:0] i_col,
    input  logic [ums_pkg::PIX_W-1:0] i_px,
    input  ums_pkg::t_meta            i_meta,
    input  logic                      i_adv,
    output logic                      o_valid,
    output ums_pkg::t_s1              o_s1
);

    logic [ums_pkg::PIX_W-1:0] mem_up  [ums_pkg::MAX_WIDTH];
    logic [ums_pkg::PIX_W-1:0] mem_mid [ums_pkg::MAX_WIDTH];

    logic                      r_valid, n_valid;
    logic [ums_pkg::COL_W-1:0] r_col;
    logic [ums_pkg::PIX_W-1:0] r_up;
    logic [ums_pkg::PIX_W-1:0] r_mid;
    logic [ums_pkg::PIX_W-1:0] r_px;
    ums_pkg::t_meta            r_meta;

    // Middle store: read old, write new at the same column.
    always_ff @(posedge i_clk) begin
        if (i_enter) begin
            r_mid          <= mem_mid[i_col];
            mem_mid[i_col] <= i_px;
        end
    end

    // Upper store takes the old middle value once it has been read.
    always_ff @(posedge i_clk) begin
        if (i_enter) begin
            r_up <= mem_up[i_col];
        end
        if (r_valid && i_adv) begin
            mem_up[r_col] <= r_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_enter) begin
            r_px   <= i_px;
            r_meta <= i_meta;
            r_col  <= i_col;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (i_enter) begin
            n_valid = 1'b1;
        end else if (i_adv) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_comb begin
        o_s1.up   = r_up;
        o_s1.mid  = r_mid;
        o_s1.px   = r_px;
        o_s1.meta = r_meta;
    end

    assign o_valid = r_valid;

endmodule

### rtl/core/ums_window.sv
// 3x3 window registers, sharpening filter and the output register.
// Depends on ums_pkg and ums_pix_out_if.
module ums_window (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ums_pkg::t_s1  i_s1,
    output logic          o_ready,
    ums_pix_out_if.source o_pix
);

    ums_pkg::t_win             r_win;
    logic                      r_s2_valid, n_s2_valid;
    ums_pkg::t_meta            r_s2_meta;
    logic                      r_ov, n_ov;
    logic [ums_pkg::PIX_W-1:0] r_pixel;
    logic                      r_frame_end;

    logic out_free, s1_take, s2_move;

    assign out_free = !r_ov || o_pix.ready;
    assign o_ready  = !r_s2_valid || out_free;
    assign s1_take  = i_valid && o_ready;
    assign s2_move  = r_s2_valid && out_free;

    always_comb begin
        n_s2_valid = r_s2_valid;
        if (s1_take) begin
            n_s2_valid = 1'b1;
        end else if (out_free) begin
            n_s2_valid = 1'b0;
        end
        n_ov = r_ov;
        if (out_free) begin
            n_ov = s2_move && r_s2_meta.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_s2_valid <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_s2_valid <= n_s2_valid;
            r_ov       <= n_ov;
            if (s1_take) begin
                // Advance each row by one column; new column enters on the right.
                for (int r = 0; r < 3; r++) begin
                    r_win[r*3]   <= r_win[r*3+1];
                    r_win[r*3+1] <= r_win[r*3+2];
                end
                r_win[2] <= i_s1.up;
                r_win[5] <= i_s1.mid;
                r_win[8] <= i_s1.px;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take) begin
            r_s2_meta <= i_s1.meta;
        end
        if (s2_move && r_s2_meta.emit) begin
            r_pixel     <= r_s2_meta.interior ? ums_pkg::sharpen(r_win) : r_win[4];
            r_frame_end <= r_s2_meta.last;
        end
    end

    assign o_pix.valid     = r_ov;
    assign o_pix.pixel_out = r_pixel;
    assign o_pix.frame_end = r_frame_end;

endmodule

### rtl/core/unsharp_mask_3x3.sv
// 3x3 unsharp mask over a raster-order greyscale frame, one transaction per clock.
// The transaction completing a window is held in the line-buffer stage, then the
// window and output registers. Throughput is one transaction per cycle with no
// gap; only a stalled output holds the input. Output trails input by width+1 pixels.
// Reset (synchronous, active low) clears counters, window and valid flags; line
// stores are not cleared and need no clearing pass.
module unsharp_mask_3x3 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ums_pix_in_if.sink    i_pix,
    ums_pix_out_if.source o_pix,
    ums_cfg_if.sink       i_cfg
);

    logic [ums_pkg::DIM_W-1:0] width, height;
    logic                      fire, enter, in_frame;
    logic [ums_pkg::COL_W-1:0] col;
    logic [ums_pkg::PIX_W-1:0] px;
    ums_pkg::t_meta            meta;
    logic                      s1_valid, s2_ready;
    ums_pkg::t_s1              s1;

    assign i_pix.ready = !s1_valid || s2_ready;
    assign fire        = i_pix.valid && i_pix.ready;
    // Pixels arriving in the tail act as drain ticks: write zero.
    assign px          = in_frame ? i_pix.pixel_in : '0;

    ums_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_width  (width),
        .o_height (height)
    );

    ums_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_width    (width),
        .i_height   (height),
        .i_fire     (fire),
        .i_cmd      (i_pix.cmd),
        .o_enter    (enter),
        .o_in_frame (in_frame),
        .o_col      (col),
        .o_meta     (meta)
    );

    ums_line_buf u_line_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enter (enter),
        .i_col   (col),
        .i_px    (px),
        .i_meta  (meta),
        .i_adv   (s2_ready),
        .o_valid (s1_valid),
        .o_s1    (s1)
    );

    ums_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_s1    (s1),
        .o_ready (s2_ready),
        .o_pix   (o_pix)
    );

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for unsharp_mask_3x3: raster frames in, sharpened pixels out.
// Depends on ums_pkg and the channel interfaces in ums_if; predicts every pixel itself.
module tb_top;

    localparam logic [ums_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = ums_pkg::CFG_IDX_W'(2);
    localparam logic [ums_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = ums_pkg::CFG_IDX_W'(3);
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic                        cmd;
        logic [ums_pkg::PIX_W-1:0]   pixel;
    } t_pix_txn;

    typedef struct packed {
        logic [ums_pkg::PIX_W-1:0]   pixel;
        logic                        frame_end;
    } t_sharp_px;

    logic i_clk;
    logic i_rst_n;

    ums_pix_in_if  pix_in();
    ums_pix_out_if pix_out();
    ums_cfg_if     cfg_wr();

    unsharp_mask_3x3 u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .i_cfg   (cfg_wr)
    );

    t_pix_txn  pixel_txn_q[$];
    t_sharp_px expected_pixels_q[$];

    int sender_idle_pct;
    int recv_idle_pct;
    int mismatch_cnt;
    int stall_cycles;

    // Predictor state
    logic [ums_pkg::DIM_W-1:0] width_reg;
    logic [ums_pkg::DIM_W-1:0] height_reg;
    logic [ums_pkg::PIX_W-1:0] row_above  [ums_pkg::MAX_WIDTH] = '{default: '0};
    logic [ums_pkg::PIX_W-1:0] row_center [ums_pkg::MAX_WIDTH] = '{default: '0};
    logic [ums_pkg::PIX_W-1:0] win [9] = '{default: '0};
    int unsigned               col_in;
    int unsigned               row_in;
    int unsigned               out_idx;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned dim_clamp(input int unsigned v, input int unsigned hi);
        if (v < 3) begin
            return 3;
        end else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Advance the frame model by one accepted transaction; return 1 when a pixel leaves.
    function automatic bit predict_sharpened(input logic cmd,
                                             input logic [ums_pkg::PIX_W-1:0] pix,
                                             output t_sharp_px res);
        int unsigned               w, h, orow, ocol;
        logic [ums_pkg::PIX_W-1:0] up, mid, px;
        logic [ums_pkg::COL_W-1:0] ci;
        bit                        tail, emit, interior, last;
        int                        sum, v, r;
        w    = dim_clamp(32'(width_reg), ums_pkg::MAX_WIDTH);
        h    = dim_clamp(32'(height_reg), ums_pkg::MAX_HEIGHT);
        tail = row_in >= h;
        res  = '0;
        // drain ticks while the frame is still arriving do nothing
        if (cmd == ums_pkg::CMD_DRAIN && !tail) begin
            return 0;
        end
        px  = tail ? '0 : pix;
        ci  = col_in[ums_pkg::COL_W-1:0];
        up  = row_above[ci];
        mid = row_center[ci];
        row_above[ci]  = mid;
        row_center[ci] = px;
        for (r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = up;
        win[5] = mid;
        win[8] = px;
        emit = (row_in >= 2) || (row_in == 1 && col_in >= 1);
        col_in++;
        if (col_in >= w) begin
            col_in = 0;
            if (row_in < 2047) begin
                row_in++;
            end
        end
        if (!emit) begin
            return 0;
        end
        orow     = out_idx / w;
        ocol     = out_idx % w;
        interior = orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w;
        if (interior) begin
            sum = int'(win[0]) + 2 * int'(win[1]) + int'(win[2])
                + 2 * int'(win[3]) + 4 * int'(win[4]) + 2 * int'(win[5])
                + int'(win[6]) + 2 * int'(win[7]) + int'(win[8]);
            v = 3 * int'(win[4]) - 2 * (sum / 16);
            if (v < 0) begin
                v = 0;
            end else if (v > 255) begin
                v = 255;
            end
            res.pixel = v[ums_pkg::PIX_W-1:0];
        end else begin
            res.pixel = win[4];
        end
        last          = out_idx >= w * h - 1;
        res.frame_end = last;
        if (last) begin
            col_in  = 0;
            row_in  = 0;
            out_idx = 0;
        end else begin
            out_idx = (out_idx + 1) & 32'h1F_FFFF;
        end
        return 1;
    endfunction

    task automatic flag_error(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // Pixel driver: hold the transaction until it is taken, idle at random between transactions
    always @(posedge i_clk) begin : driver
        t_pix_txn nxt;
        if (!i_rst_n) begin
            pix_in.valid <= 1'b0;
        end else if (!pix_in.valid || pix_in.ready) begin
            if (pixel_txn_q.size() != 0 && int'($urandom_range(99)) >= sender_idle_pct) begin
                nxt = pixel_txn_q.pop_front();
                pix_in.valid    <= 1'b1;
                pix_in.cmd      <= nxt.cmd;
                pix_in.pixel_in <= nxt.pixel;
            end else begin
                pix_in.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : sink_ready
        if (!i_rst_n) begin
            pix_out.ready <= 1'b0;
        end else begin
            pix_out.ready <= int'($urandom_range(99)) >= recv_idle_pct;
        end
    end

    // Check outputs first, then predict from the input taken at the same edge
    always @(posedge i_clk) begin : monitor
        t_sharp_px got, want, pred;
        if (i_rst_n) begin
            if (pix_out.valid && pix_out.ready) begin
                got.pixel     = pix_out.pixel_out;
                got.frame_end = pix_out.frame_end;
                if (expected_pixels_q.size() == 0) begin
                    flag_error($sformatf("unexpected pixel %0d frame_end %0b",
                                         got.pixel, got.frame_end));
                end else begin
                    want = expected_pixels_q.pop_front();
                    if (got.pixel !== want.pixel || got.frame_end !== want.frame_end) begin
                        flag_error($sformatf("pixel exp %0d got %0d, frame_end exp %0b got %0b",
                                             want.pixel, got.pixel,
                                             want.frame_end, got.frame_end));
                    end
                end
            end
            if (pix_in.valid && pix_in.ready) begin
                if (predict_sharpened(pix_in.cmd, pix_in.pixel_in, pred)) begin
                    expected_pixels_q.push_back(pred);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)
                || (cfg_wr.valid && cfg_wr.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_txn(input logic cmd, input logic [ums_pkg::PIX_W-1:0] pixel);
        t_pix_txn t;
        t.cmd   = cmd;
        t.pixel = pixel;
        pixel_txn_q.push_back(t);
    endtask

    // Wait until the block has drained, allowing for results still in the pipe
    task automatic settle();
        do begin
            while (pixel_txn_q.size() != 0 || pix_in.valid || expected_pixels_q.size() != 0) begin
                @(posedge i_clk);
            end
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end while (pixel_txn_q.size() != 0 || pix_in.valid || expected_pixels_q.size() != 0);
    endtask

    task automatic write_reg(input logic [ums_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ums_pkg::DIM_W-1:0] val);
        @(posedge i_clk);
        cfg_wr.valid <= 1'b1;
        cfg_wr.addr  <= idx;
        cfg_wr.data  <= val;
        do begin
            @(posedge i_clk);
        end while (!cfg_wr.ready);
        cfg_wr.valid <= 1'b0;
        if (idx == ums_pkg::REG_IMAGE_WIDTH) begin
            width_reg = val;
        end else if (idx == ums_pkg::REG_IMAGE_HEIGHT) begin
            height_reg = val;
        end
    endtask

    task automatic configure(input int unsigned wv, input int unsigned hv);
        settle();
        write_reg(ums_pkg::REG_IMAGE_WIDTH, ums_pkg::DIM_W'(wv));
        write_reg(ums_pkg::REG_IMAGE_HEIGHT, ums_pkg::DIM_W'(hv));
    endtask

    // Queue whole frames at the current size, with stray drains and mixed tail ticks
    task automatic gen_frames(input int unsigned nframes);
        int unsigned               w, h, f, k;
        int                        style;
        logic [ums_pkg::PIX_W-1:0] base, val;
        w = dim_clamp(32'(width_reg), ums_pkg::MAX_WIDTH);
        h = dim_clamp(32'(height_reg), ums_pkg::MAX_HEIGHT);
        for (f = 0; f < nframes; f++) begin
            style = $urandom_range(2);
            base  = ums_pkg::PIX_W'($urandom);
            for (k = 0; k < w * h; k++) begin
                if ($urandom_range(15) == 0) begin
                    push_txn(ums_pkg::CMD_DRAIN, ums_pkg::PIX_W'($urandom));
                end
                case (style)
                    0: val = ums_pkg::PIX_W'($urandom);
                    1: val = base + ums_pkg::PIX_W'($urandom_range(15));
                    default: val = $urandom_range(1) ? 8'hFF : 8'h00;
                endcase
                push_txn(ums_pkg::CMD_PIXEL, val);
            end
            for (k = 0; k <= w; k++) begin
                push_txn($urandom_range(4) == 0 ? ums_pkg::CMD_PIXEL : ums_pkg::CMD_DRAIN,
                         ums_pkg::PIX_W'($urandom));
            end
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 2)) begin
                    push_txn(ums_pkg::CMD_DRAIN, ums_pkg::PIX_W'($urandom));
                end
            end
        end
    endtask

    initial begin : stimulus
        int k;
        cfg_wr.valid    = 1'b0;
        cfg_wr.addr     = ums_pkg::REG_IMAGE_WIDTH;
        cfg_wr.data     = '0;
        width_reg       = ums_pkg::WIDTH_RESET;
        height_reg      = ums_pkg::HEIGHT_RESET;
        sender_idle_pct = 27;
        recv_idle_pct   = 71;
        i_rst_n         = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Smallest frame; writes to unused indexes must leave the size alone
        configure(3, 3);
        write_reg(REG_SPARE_2, 11'h7FF);
        write_reg(REG_SPARE_3, 11'h000);

        // Bright center on black: result saturates high
        for (k = 0; k < 9; k++) begin
            push_txn(ums_pkg::CMD_PIXEL, k == 4 ? 8'hFF : 8'h00);
            if (k == 3) begin
                push_txn(ums_pkg::CMD_DRAIN, 8'h00);
            end
        end
        push_txn(ums_pkg::CMD_DRAIN, 8'h00);
        push_txn(ums_pkg::CMD_PIXEL, 8'hA5);
        push_txn(ums_pkg::CMD_DRAIN, 8'hFF);
        push_txn(ums_pkg::CMD_PIXEL, 8'h5A);
        push_txn(ums_pkg::CMD_DRAIN, 8'h00);
        // Dark center on white: result saturates low
        for (k = 0; k < 9; k++) begin
            push_txn(ums_pkg::CMD_PIXEL, k == 4 ? 8'h00 : 8'hFF);
        end
        repeat (4) push_txn(ums_pkg::CMD_DRAIN, 8'h00);

        // Mid-size frames, then sizes below the minimum that saturate to 3x3
        configure(8, 5);
        gen_frames(2);
        configure(2, 0);
        gen_frames(3);

        // Swap idling: slow sender, mostly ready receiver
        settle();
        sender_idle_pct = 71;
        recv_idle_pct   = 27;
        configure(16, 6);
        gen_frames(2);
        configure(4, 3);
        gen_frames(2);

        // Neither side idles
        settle();
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        configure(5, 7);
        gen_frames(4);
        configure(13, 9);
        gen_frames(1);

        settle();
        if (mismatch_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### unsharp_mask_3x3.f
rtl/core/ums_pkg.sv
rtl/core/ums_if.sv
rtl/core/ums_cfg.sv
rtl/core/ums_ctrl.sv
rtl/core/ums_line_buf.sv
rtl/core/ums_window.sv
rtl/core/unsharp_mask_3x3.sv
sim/tb_top.sv
